[src/lzfu_pkg.sv]
// Shared types, constants and the RTF prefix table of the LZFu decompressor.
package lzfu_pkg;

	localparam int DICT_AW    = 12;
	localparam int PREFIX_LEN = 207;

	typedef logic [DICT_AW-1:0] addr_t;

	localparam addr_t WP_START = addr_t'(PREFIX_LEN);

	localparam logic [8*PREFIX_LEN-1:0] RTF_PREFIX = {
		"{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
		"{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript \\fdecor ",
		"MS Sans SerifSymbolArialTimes New RomanCourier",
		"{\\colortbl\\red0\\green0\\blue0",
		"\015\012\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
	};

	typedef struct packed {
		logic restart;
		logic load_flag;
		logic use_bit;
		logic hold_high;
		logic take_literal;
		logic start_copy;
		logic issue;
	} cmd_t;

	typedef struct packed {
		logic bits_empty;
		logic ctrl_bit0;
		logic end_hit;
		logic copy_last;
		logic s1_busy;
		logic adv;
	} stat_t;

	function automatic logic [7:0] prefix_byte(input addr_t a);
		logic [7:0] b;
		b = 8'h00;
		if (a < addr_t'(PREFIX_LEN)) begin
			b = RTF_PREFIX[8*(PREFIX_LEN-1-int'(a)) +: 8];
		end
		return b;
	endfunction

endpackage

[src/lzfu_ifs.sv]
// Stream interfaces for compressed input and decompressed output transactions.
interface lzfu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_start;

	modport source(output valid, output data_byte, output stream_start, input ready);
	modport sink(input valid, input data_byte, input stream_start, output ready);
endinterface

interface lzfu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source(output valid, output out_byte, output run_last, input ready);
	modport sink(input valid, input out_byte, input run_last, output ready);
endinterface

[src/lzfu_rtf_decompressor_unit.sv]
// Top level of the LZFu compressed RTF payload decompressor.
// Takes the payload bytes after the 16-byte header, one per transaction, and
// returns decompressed bytes, with run_last marking the final byte of each
// input transaction. Flag bytes and first token bytes give no output; a literal
// gives one byte; a token's second byte starts a copy of its length (2 to 17).
// The single dictionary memory does one read and one write per cycle while the
// output is not stalled, one copied byte each, and the read stage drains
// before the next transaction. A transaction with
// stream_start high restarts the parser and dictionary at once: unwritten
// dictionary entries read as the RTF prefix or zero through a fill count, so
// there is no clearing pass after reset. After the end token, bytes are dropped
// until the next stream_start.
module lzfu_rtf_decompressor_unit (
	input logic clk,
	input logic arst_n,
	lzfu_in_if.sink    comp,
	lzfu_out_if.source decomp
);

	lzfu_pkg::cmd_t  cmd;
	lzfu_pkg::stat_t stat;

	lzfu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (comp.valid),
		.stream_start (comp.stream_start),
		.ready        (comp.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	lzfu_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (comp.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (decomp.valid),
		.out_ready (decomp.ready),
		.out_byte  (decomp.out_byte),
		.run_last  (decomp.run_last)
	);

endmodule

[src/lzfu_ctrl.sv]
// Controller: parses flag, literal and token bytes and sequences dictionary copies.
module lzfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  logic           stream_start,
	output logic           ready,
	input  lzfu_pkg::stat_t stat,
	output lzfu_pkg::cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_COPY
	} state_t;

	state_t state_q;
	logic   pending_q;
	logic   finished_q;
	logic   acc;
	logic   eff_fin;
	logic   eff_pending;
	logic   eff_empty;
	logic   parse;

	assign ready       = (state_q == ST_IDLE) && !stat.s1_busy && stat.adv;
	assign acc         = valid && ready;
	assign eff_fin     = finished_q && !stream_start;
	assign eff_pending = pending_q && !stream_start;
	assign eff_empty   = stat.bits_empty || stream_start;
	assign parse       = acc && !eff_fin;

	always_comb begin
		cmd              = '0;
		cmd.restart      = acc && stream_start;
		cmd.load_flag    = parse && eff_empty;
		cmd.use_bit      = parse && !eff_empty && (eff_pending || !stat.ctrl_bit0);
		cmd.hold_high    = parse && !eff_empty && !eff_pending && stat.ctrl_bit0;
		cmd.take_literal = parse && !eff_empty && !eff_pending && !stat.ctrl_bit0;
		cmd.start_copy   = parse && !eff_empty && eff_pending && !stat.end_hit;
		cmd.issue        = (state_q == ST_COPY) && stat.adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pending_q  <= 1'b0;
			finished_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				pending_q  <= 1'b0;
				finished_q <= 1'b0;
			end
			if (cmd.hold_high) begin
				pending_q <= 1'b1;
			end
			if (parse && !eff_empty && eff_pending) begin
				pending_q <= 1'b0;
				if (stat.end_hit) begin
					finished_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start_copy) begin
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (cmd.issue && stat.copy_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/lzfu_datapath.sv]
// Datapath: dictionary memory, fill tracking, copy pointers, read stage and output register.
module lzfu_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      data_byte,
	input  lzfu_pkg::cmd_t  cmd,
	output lzfu_pkg::stat_t stat,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	logic [7:0]      mem [2**lzfu_pkg::DICT_AW];
	logic [7:0]      ctrl_q;
	logic [3:0]      bits_q;
	logic [7:0]      hi_q;
	lzfu_pkg::addr_t wp_q;
	lzfu_pkg::addr_t fill_q;
	logic            full_q;
	lzfu_pkg::addr_t raddr_q;
	logic [4:0]      rem_q;
	logic            valid_s1;
	logic            hit_s1;
	logic            fwd_s1;
	logic            last_s1;
	logic [7:0]      def_s1;
	logic [7:0]      rdata_q;
	logic [7:0]      prev_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            run_last_q;
	logic            adv;
	logic            wr_en;
	logic [7:0]      byte_s1;
	logic            hit;
	logic            fwd;

	assign adv     = !out_valid_q || out_ready;
	assign wr_en   = adv && valid_s1;
	assign byte_s1 = fwd_s1 ? prev_q : (hit_s1 ? rdata_q : def_s1);
	assign hit     = full_q || ((raddr_q - lzfu_pkg::WP_START) < fill_q);
	assign fwd     = valid_s1 && (raddr_q == wp_q);

	assign stat.bits_empty = (bits_q == 4'd0);
	assign stat.ctrl_bit0  = ctrl_q[0];
	assign stat.end_hit    = ({hi_q, data_byte[7:4]} == wp_q);
	assign stat.copy_last  = (rem_q == 5'd0);
	assign stat.s1_busy    = valid_s1;
	assign stat.adv        = adv;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdata_q <= mem[raddr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= 8'h00;
			bits_q      <= 4'd0;
			wp_q        <= lzfu_pkg::WP_START;
			fill_q      <= '0;
			full_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				wp_q   <= lzfu_pkg::WP_START;
				fill_q <= '0;
				full_q <= 1'b0;
			end
			if (cmd.load_flag) begin
				ctrl_q <= data_byte;
				bits_q <= 4'd8;
			end
			if (cmd.use_bit) begin
				ctrl_q <= {1'b0, ctrl_q[7:1]};
				if (bits_q != 4'd0) begin
					bits_q <= bits_q - 4'd1;
				end
			end
			// commit the stage byte to the dictionary
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
				if (!full_q) begin
					if (fill_q == '1) begin
						full_q <= 1'b1;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
			end
			if (adv) begin
				valid_s1    <= cmd.take_literal || cmd.issue;
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_high) begin
			hi_q <= data_byte;
		end
		if (cmd.start_copy) begin
			raddr_q <= {hi_q, data_byte[7:4]};
			rem_q   <= {1'b0, data_byte[3:0]} + 5'd1;
		end
		if (cmd.take_literal) begin
			def_s1  <= data_byte;
			hit_s1  <= 1'b0;
			fwd_s1  <= 1'b0;
			last_s1 <= 1'b1;
		end
		if (cmd.issue) begin
			def_s1  <= lzfu_pkg::prefix_byte(raddr_q);
			hit_s1  <= hit;
			fwd_s1  <= fwd;
			last_s1 <= (rem_q == 5'd0);
			raddr_q <= raddr_q + 1'b1;
			rem_q   <= rem_q - 5'd1;
		end
		if (wr_en) begin
			prev_q     <= byte_s1;
			out_byte_q <= byte_s1;
			run_last_q <= last_s1;
		end
	end

endmodule

[bench/tb_lzfu_rtf_decompressor_unit.sv]
// Self-checking bench for the LZFu payload decompressor: random compressed streams, byte checks.
`timescale 1ns / 100ps

module tb_lzfu_rtf_decompressor_unit;

	localparam int DICT_DEPTH   = 1 << lzfu_pkg::DICT_AW;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int CALM_FROM    = 2000;
	localparam int CALM_TO      = 5000;
	localparam int DIRECTED_LEN = 21;

	// {stream_start, data_byte}
	localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
		9'h05C, 9'h000, 9'h0FF, 9'h000, 9'h00F, 9'h00E, 9'h010, 9'h0FF, 9'h0F1,
		9'h0A5, 9'h080, 9'h000, 9'h05A,
		9'h001, 9'h00E, 9'h0B7, 9'h03C,
		9'h103, 9'h012, 9'h100, 9'h081
	};

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} comp_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} plain_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   err_count = 0;

	lzfu_in_if  comp_ch();
	lzfu_out_if decomp_ch();

	lzfu_rtf_decompressor_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.comp(comp_ch),
		.decomp(decomp_ch)
	);

	comp_item_t  comp_items[$];
	plain_byte_t plain_bytes[$];

	logic [7:0]      dict_mem [DICT_DEPTH];
	lzfu_pkg::addr_t wr_pos;
	logic [7:0]      ctrl_bits;
	logic [3:0]      bits_avail;
	logic            tok_wait;
	logic [7:0]      tok_hi;
	logic            stream_done;

	int gen_wp;
	int gen_out;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic bit take_break();
		return !(cycle_count >= CALM_FROM && cycle_count < CALM_TO) && $urandom_range(99) < 36;
	endfunction

	function automatic void restart_stream();
		for (int a = 0; a < DICT_DEPTH; a++)
			dict_mem[a] = (a < lzfu_pkg::PREFIX_LEN) ?
				lzfu_pkg::RTF_PREFIX[8*(lzfu_pkg::PREFIX_LEN-1-a) +: 8] : 8'h00;
		wr_pos      = lzfu_pkg::WP_START;
		ctrl_bits   = 8'h00;
		bits_avail  = 4'd0;
		tok_wait    = 1'b0;
		tok_hi      = 8'h00;
		stream_done = 1'b0;
	endfunction

	function automatic void shift_flag();
		ctrl_bits = ctrl_bits >> 1;
		if (bits_avail != 0)
			bits_avail = bits_avail - 1'b1;
	endfunction

	function automatic void append_plain(input logic [7:0] b, input logic last);
		dict_mem[wr_pos] = b;
		wr_pos = wr_pos + 1'b1;
		plain_bytes.push_back(plain_byte_t'{b, last});
	endfunction

	// Expected plain bytes caused by one accepted compressed byte.
	function automatic void decompress_byte(input logic [7:0] b, input logic start);
		logic [15:0]     word;
		lzfu_pkg::addr_t src;
		int              run_len;
		if (start)
			restart_stream();
		if (stream_done)
			return;
		if (bits_avail == 0) begin
			ctrl_bits  = b;
			bits_avail = 4'd8;
			return;
		end
		if (tok_wait) begin
			word    = {tok_hi, b};
			src     = word[15:4];
			run_len = int'(word[3:0]) + 2;
			tok_wait = 1'b0;
			shift_flag();
			if (src == wr_pos) begin
				stream_done = 1'b1;
				return;
			end
			for (int i = 0; i < run_len; i++)
				append_plain(dict_mem[lzfu_pkg::addr_t'(src + lzfu_pkg::addr_t'(i))],
					i == run_len - 1);
			return;
		end
		if (ctrl_bits[0]) begin
			tok_hi   = b;
			tok_wait = 1'b1;
			return;
		end
		shift_flag();
		append_plain(b, 1'b1);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("[%0t] MISMATCH %s: got %02h want %02h", $time, what, got, want);
		err_count++;
	endtask

	function automatic void push_comp(input logic [7:0] data, input logic start);
		comp_items.push_back(comp_item_t'{data, start});
	endfunction

	function automatic void push_token(input int src, input int nib);
		push_comp(8'(src >> 4), 1'b0);
		push_comp({4'(src), 4'(nib)}, 1'b0);
		gen_wp  = (gen_wp + nib + 2) % DICT_DEPTH;
		gen_out = gen_out + nib + 2;
	endfunction

	// One flag byte and up to eight literals or tokens, never an accidental end token.
	function automatic void gen_group(input logic start, input bit long_run, input int n_elems);
		logic [7:0] flags;
		int src;
		if (start)
			gen_wp = lzfu_pkg::PREFIX_LEN;
		if (long_run && $urandom_range(3) != 0)
			flags = 8'hFF;
		else
			flags = 8'($urandom);
		push_comp(flags, start);
		for (int e = 0; e < n_elems; e++) begin
			if (flags[e]) begin
				case ($urandom_range(3))
				0: src = $urandom_range(DICT_DEPTH - 1);
				1: src = (gen_wp + DICT_DEPTH - $urandom_range(1, 20)) % DICT_DEPTH;
				2: src = $urandom_range(lzfu_pkg::PREFIX_LEN - 1);
				default: src = $urandom_range(DICT_DEPTH - 1, DICT_DEPTH - 16);
				endcase
				if (src == gen_wp)
					src = (src + 1) % DICT_DEPTH;
				push_token(src, long_run ? $urandom_range(12, 15) : $urandom_range(15));
			end else begin
				push_comp(8'($urandom), 1'b0);
				gen_wp = (gen_wp + 1) % DICT_DEPTH;
				gen_out++;
			end
		end
	endfunction

	function automatic void build_stimulus();
		int target;
		int pick;
		for (int k = 0; k < DIRECTED_LEN; k++)
			push_comp(DIRECTED[k][7:0], DIRECTED[k][8]);

		// long stream: groups of long copies, overlapping and wrapping reads
		gen_out = 0;
		gen_group(1'b1, 1'b1, 8);
		while (gen_out < 1200)
			gen_group(1'b0, 1'b1, 8);

		target = comp_items.size() + 165;
		while (comp_items.size() < target) begin
			pick = $urandom_range(99);
			if (pick < 88) begin
				gen_group(1'b1, 1'b0, 8);
				repeat ($urandom_range(4))
					gen_group(1'b0, 1'b0, 8);
				pick = $urandom_range(99);
				if (pick < 25) begin
					push_comp(8'($urandom) | 8'h01, 1'b0);
					push_token(gen_wp, $urandom_range(15));
					repeat ($urandom_range(4))
						push_comp(8'($urandom), 1'b0);
				end else if (pick < 45) begin
					gen_group(1'b0, 1'b0, $urandom_range(7));
					push_comp(8'($urandom), 1'b0);
				end
			end else begin
				repeat ($urandom_range(5, 15))
					push_comp(8'($urandom), $urandom_range(9) == 0);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			comp_ch.valid <= 1'b0;
		end else if (!comp_ch.valid || comp_ch.ready) begin
			if (comp_items.size() != 0 && !take_break()) begin
				comp_ch.valid        <= 1'b1;
				comp_ch.data_byte    <= comp_items[0].data;
				comp_ch.stream_start <= comp_items[0].start;
				void'(comp_items.pop_front());
			end else begin
				comp_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			decomp_ch.ready <= 1'b0;
		else
			decomp_ch.ready <= !take_break();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (comp_ch.valid && comp_ch.ready)
				decompress_byte(comp_ch.data_byte, comp_ch.stream_start);
			if (decomp_ch.valid && decomp_ch.ready) begin
				if (plain_bytes.size() == 0) begin
					report_mismatch("byte with nothing expected", decomp_ch.out_byte, 8'h00);
				end else begin
					if (decomp_ch.out_byte !== plain_bytes[0].data)
						report_mismatch("out_byte", decomp_ch.out_byte, plain_bytes[0].data);
					if (decomp_ch.run_last !== plain_bytes[0].last)
						report_mismatch("run_last", 8'(decomp_ch.run_last),
							8'(plain_bytes[0].last));
					void'(plain_bytes.pop_front());
				end
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		comp_ch.valid        = 1'b0;
		comp_ch.data_byte    = 8'h00;
		comp_ch.stream_start = 1'b0;
		decomp_ch.ready      = 1'b0;
		restart_stream();
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (comp_items.size() != 0 || comp_ch.valid)
			@(negedge clk);
		while (plain_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
src/lzfu_pkg.sv
src/lzfu_ifs.sv
src/lzfu_ctrl.sv
src/lzfu_datapath.sv
src/lzfu_rtf_decompressor_unit.sv
bench/tb_lzfu_rtf_decompressor_unit.sv
